// ===== sv/optc_pkg.sv =====
package optc_pkg;

  // Field widths
  localparam int unsigned WordW    = 32;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned WidthW   = 8;
  localparam int unsigned VerdictW = 2;
  localparam int unsigned IndexW   = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 24;  // verdict + index, padded to bytes

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegOrbitChannel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOrbitPeriod  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPulseWidth   = 2'd2;

  // Register reset values
  localparam logic [ChanW-1:0]   OrbitChannelRst = 5'd0;
  localparam logic [PeriodW-1:0] OrbitPeriodRst  = 16'd3564;
  localparam logic [WidthW-1:0]  PulseWidthRst   = 8'd40;

  // Verdict codes
  localparam logic [VerdictW-1:0] VerdictOk       = 2'd0;
  localparam logic [VerdictW-1:0] VerdictNoPulse  = 2'd1;
  localparam logic [VerdictW-1:0] VerdictZeroIn   = 2'd2;
  localparam logic [VerdictW-1:0] VerdictOneOut   = 2'd3;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhHigh   = 2'd1,
    PhLow    = 2'd2,
    PhError  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ChanW-1:0]   orbit_channel;
    logic [PeriodW-1:0] orbit_period;
    logic [WidthW-1:0]  pulse_width;
  } cfg_t;

  typedef struct packed {
    logic [IndexW-1:0]   first_pulse_index;
    logic [VerdictW-1:0] verdict;
  } result_t;

endpackage

// ===== sv/optc_check.sv =====
module optc_check import optc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1048576
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [WordW-1:0] word_i,
  input  logic             last_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam int unsigned SmpW = $clog2(MAX_SAMPLES + 1);

  phase_e              phase_q, phase_d;
  logic                retry_q, retry_d;
  logic [PeriodW-1:0]  pos_q, pos_d;
  logic [SmpW-1:0]     smp_q, smp_d;
  logic [IndexW-1:0]   start_q, start_d;
  logic [VerdictW-1:0] err_q, err_d;

  logic [PeriodW-1:0]  eff;
  logic                bit_s;
  logic                in_range;
  logic [PeriodW-1:0]  pos_cur;
  logic [PeriodW:0]    pos_inc;
  logic [PeriodW-1:0]  pos_nxt;

  assign bit_s    = word_i[cfg_i.orbit_channel];
  assign in_range = smp_q < SmpW'(MAX_SAMPLES);

  always_comb begin
    eff = (cfg_i.orbit_period > PeriodW'(cfg_i.pulse_width)) ?
          cfg_i.orbit_period : PeriodW'(cfg_i.pulse_width);
    if (eff == '0) begin
      eff = PeriodW'(1);
    end
  end

  assign pos_cur = (phase_q == PhSearch) ? '0 : pos_q;
  assign pos_inc = {1'b0, pos_cur} + 1'b1;
  assign pos_nxt = (pos_inc >= {1'b0, eff}) ? '0 : pos_inc[PeriodW-1:0];

  always_comb begin
    phase_d = phase_q;
    retry_d = retry_q;
    pos_d   = pos_q;
    smp_d   = smp_q;
    start_d = start_q;
    err_d   = err_q;
    res_o.verdict           = VerdictOk;
    res_o.first_pulse_index = '0;
    res_valid_o             = fire_i && last_i;

    if (fire_i && in_range) begin
      smp_d = smp_q + 1'b1;
      if (phase_q != PhError && (phase_q != PhSearch || bit_s)) begin
        if (phase_q == PhSearch) begin
          start_d = IndexW'(smp_q);
        end
        if (pos_cur < PeriodW'(cfg_i.pulse_width)) begin
          if (!bit_s) begin
            // dropout inside the pulse: forgive once, then it is fatal
            if (retry_q) begin
              err_d   = VerdictZeroIn;
              phase_d = PhError;
            end else begin
              retry_d = 1'b1;
              phase_d = PhSearch;
              pos_d   = '0;
            end
          end else begin
            pos_d   = pos_nxt;
            phase_d = (pos_nxt < PeriodW'(cfg_i.pulse_width)) ? PhHigh : PhLow;
          end
        end else if (bit_s) begin
          err_d   = VerdictOneOut;
          phase_d = PhError;
        end else begin
          pos_d   = pos_nxt;
          phase_d = (pos_nxt < PeriodW'(cfg_i.pulse_width)) ? PhHigh : PhLow;
        end
      end
    end

    if (phase_d == PhError) begin
      res_o.verdict = err_d;
    end else if (phase_d == PhSearch) begin
      res_o.verdict = VerdictNoPulse;
    end else begin
      res_o.verdict = VerdictOk;
    end
    res_o.first_pulse_index = (res_o.verdict == VerdictNoPulse) ? '0 : start_d;

    if (fire_i && last_i) begin
      phase_d = PhSearch;
      retry_d = 1'b0;
      pos_d   = '0;
      smp_d   = '0;
      start_d = '0;
      err_d   = VerdictOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      retry_q <= 1'b0;
      pos_q   <= '0;
      smp_q   <= '0;
      start_q <= '0;
      err_q   <= VerdictOk;
    end else begin
      phase_q <= phase_d;
      retry_q <= retry_d;
      pos_q   <= pos_d;
      smp_q   <= smp_d;
      start_q <= start_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== sv/orbit_pulse_train_checker_core.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = sample_word, s_tlast = last
// m_*       out  m_tvalid/m_tready  m_tdata = verdict, first_pulse_index
// cfg_*     in   cfg_we (no wait)   cfg_index selects register, cfg_data value
//
// One sample per clock, sustained. A sample is registered on transfer and
// checked from the input register; its result (on last only) lands in a
// two-entry output buffer, whose head register offers the verdict.
// s_tready drops only while a registered last sample waits on a full buffer.
// rst_ni clears the check state and loads the register reset values.
module orbit_pulse_train_checker_core import optc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1048576
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [WordW-1:0]    s_tdata,   // [31:0] sample_word
  input  logic                s_tlast,   // last sample of the snapshot
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [1:0] verdict, [21:2] first_pulse_index
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orbit_channel <= OrbitChannelRst;
      cfg_q.orbit_period  <= OrbitPeriodRst;
      cfg_q.pulse_width   <= PulseWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOrbitChannel: cfg_q.orbit_channel <= cfg_data_i[ChanW-1:0];
        RegOrbitPeriod:  cfg_q.orbit_period  <= cfg_data_i[PeriodW-1:0];
        RegPulseWidth:   cfg_q.pulse_width   <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic             in_valid_q;
  logic [WordW-1:0] in_word_q;
  logic             in_last_q;
  logic             buf_full;
  logic             advance;
  logic             fire;

  // output buffer: head register plus skid entry
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    res_valid;
  result_t res;
  logic    pop;

  assign buf_full = out_valid_q && skid_valid_q;
  assign advance  = !(in_valid_q && in_last_q && buf_full);
  assign fire     = in_valid_q && advance;
  assign s_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_word_q <= s_tdata;
      in_last_q <= s_tlast;
    end
  end

  optc_check #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .word_i     (in_word_q),
    .last_i     (in_last_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign pop = out_valid_q && m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = OutDataW'({out_q.first_pulse_index, out_q.verdict});

endmodule
